### rtl/core/htpfd_pkg.sv
// ----------------------------------------------------------------------------
// htpfd_pkg
// shared types and constants of the humidity/temperature pulse frame decoder
// ----------------------------------------------------------------------------
package htpfd_pkg;

  localparam int unsigned FRAME_BYTES   = 5;
  localparam int unsigned FRAME_BITS    = FRAME_BYTES * 8;
  localparam int unsigned CNT_W         = $clog2(FRAME_BITS + 1);
  localparam int unsigned WIDTH_BITS    = 10;

  localparam int unsigned ZERO_MIN_RST  = 20;
  localparam int unsigned ZERO_MAX_RST  = 30;

  localparam int unsigned WORD_W        = 16;
  localparam int unsigned HUM_WHOLE_W   = 13;
  localparam int unsigned TMP_WHOLE_W   = 12;
  localparam int unsigned TENTHS_W      = 4;

  // x / 10 == (x * 0xcccd) >> 19 for every 16-bit x
  localparam logic [15:0] DIV10_RECIP   = 16'hcccd;
  localparam int unsigned DIV10_SHIFT   = 19;

  localparam int unsigned CFG_IDX_W     = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ZERO_WIDTH_MIN = 1'b0,
    CFG_ZERO_WIDTH_MAX = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic                  valid;
    logic [FRAME_BITS-1:0] bits;
  } frame_t;

  typedef struct packed {
    logic                   checksum_ok;
    logic [HUM_WHOLE_W-1:0] humidity_whole;
    logic [TENTHS_W-1:0]    humidity_tenths;
    logic                   temperature_negative;
    logic [TMP_WHOLE_W-1:0] temperature_whole;
    logic [TENTHS_W-1:0]    temperature_tenths;
  } result_t;

endpackage

### rtl/core/htpfd_if.sv
// ----------------------------------------------------------------------------
// htpfd_if
// valid/ready channels for pulse items and decoded result items
// ----------------------------------------------------------------------------
interface htpfd_pulse_if #(
  parameter int unsigned WIDTH_BITS = htpfd_pkg::WIDTH_BITS
);
  logic                  valid;
  logic                  ready;
  logic [WIDTH_BITS-1:0] pulse_width;
  logic                  frame_start;

  modport source (output valid, output pulse_width, output frame_start, input ready);
  modport sink   (input valid, input pulse_width, input frame_start, output ready);
endinterface

interface htpfd_result_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 checksum_ok;
  logic [htpfd_pkg::HUM_WHOLE_W-1:0]    humidity_whole;
  logic [htpfd_pkg::TENTHS_W-1:0]       humidity_tenths;
  logic                                 temperature_negative;
  logic [htpfd_pkg::TMP_WHOLE_W-1:0]    temperature_whole;
  logic [htpfd_pkg::TENTHS_W-1:0]       temperature_tenths;

  modport source (
    output valid, output checksum_ok, output humidity_whole, output humidity_tenths,
    output temperature_negative, output temperature_whole, output temperature_tenths,
    input ready
  );
  modport sink (
    input valid, input checksum_ok, input humidity_whole, input humidity_tenths,
    input temperature_negative, input temperature_whole, input temperature_tenths,
    output ready
  );
endinterface

### rtl/core/htpfd_accum.sv
// ----------------------------------------------------------------------------
// htpfd_accum
// classifies each pulse width as a bit and shifts it into the frame,
// handing a complete frame to the frame register
// ----------------------------------------------------------------------------
module htpfd_accum #(
  parameter int unsigned WIDTH_BITS = htpfd_pkg::WIDTH_BITS
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [WIDTH_BITS-1:0]   zero_min_i,
  input  logic [WIDTH_BITS-1:0]   zero_max_i,
  htpfd_pulse_if.sink             pulse_i,
  output htpfd_pkg::frame_t       frame_o,
  input  logic                    frame_ready_i
);

  logic [htpfd_pkg::FRAME_BITS-1:0] bits_q, bits_d, base_bits, shifted;
  logic [htpfd_pkg::CNT_W-1:0]      cnt_q, cnt_d, base_cnt, cnt_inc;
  logic [htpfd_pkg::FRAME_BITS-1:0] frame_bits_q;
  logic                             frame_vld_q, frame_vld_d;
  logic                             bit_one, accept, done;

  assign pulse_i.ready = !frame_vld_q || frame_ready_i;
  assign accept        = pulse_i.valid && pulse_i.ready;

  assign bit_one   = !((pulse_i.pulse_width >= zero_min_i) &&
                       (pulse_i.pulse_width <= zero_max_i));
  assign base_bits = pulse_i.frame_start ? '0 : bits_q;
  assign base_cnt  = pulse_i.frame_start ? '0 : cnt_q;
  assign shifted   = {base_bits[htpfd_pkg::FRAME_BITS-2:0], bit_one};
  assign cnt_inc   = base_cnt + htpfd_pkg::CNT_W'(1);
  assign done      = (cnt_inc == htpfd_pkg::CNT_W'(htpfd_pkg::FRAME_BITS));

  always_comb begin
    bits_d      = bits_q;
    cnt_d       = cnt_q;
    frame_vld_d = frame_vld_q && !frame_ready_i;
    if (accept) begin
      if (done) begin
        bits_d      = '0;
        cnt_d       = '0;
        frame_vld_d = 1'b1;
      end else begin
        bits_d = shifted;
        cnt_d  = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q      <= '0;
      cnt_q       <= '0;
      frame_vld_q <= 1'b0;
    end else begin
      bits_q      <= bits_d;
      cnt_q       <= cnt_d;
      frame_vld_q <= frame_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && done) begin
      frame_bits_q <= shifted;
    end
  end

  assign frame_o.valid = frame_vld_q;
  assign frame_o.bits  = frame_bits_q;

endmodule

### rtl/core/htpfd_decode.sv
// ----------------------------------------------------------------------------
// htpfd_decode
// checksum test and split of humidity and temperature into whole and tenths,
// held in the result register
// ----------------------------------------------------------------------------
module htpfd_decode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  htpfd_pkg::frame_t   frame_i,
  output logic                frame_ready_o,
  htpfd_result_if.source      result_o
);

  logic [7:0]                      b0, b1, b2, b3, b4, sum;
  logic [htpfd_pkg::WORD_W-1:0]    hum;
  logic [htpfd_pkg::WORD_W-2:0]    mag;
  logic [31:0]                     hum_prod;
  logic [30:0]                     mag_prod;
  logic [htpfd_pkg::HUM_WHOLE_W-1:0] hum_q10;
  logic [htpfd_pkg::TMP_WHOLE_W-1:0] mag_q10;
  logic [16:0]                     hum_x10, mag_x10, hum_rem, mag_rem;
  logic                            ok, load;
  htpfd_pkg::result_t              res_d, res_q;
  logic                            out_vld_q;

  assign b0 = frame_i.bits[39:32];
  assign b1 = frame_i.bits[31:24];
  assign b2 = frame_i.bits[23:16];
  assign b3 = frame_i.bits[15:8];
  assign b4 = frame_i.bits[7:0];

  assign sum = b0 + b1 + b2 + b3;
  assign ok  = (sum == b4);

  assign hum = {b0, b1};
  assign mag = {b2[6:0], b3};

  assign hum_prod = hum * htpfd_pkg::DIV10_RECIP;
  assign mag_prod = mag * htpfd_pkg::DIV10_RECIP;
  assign hum_q10  = hum_prod[31:htpfd_pkg::DIV10_SHIFT];
  assign mag_q10  = mag_prod[30:htpfd_pkg::DIV10_SHIFT];

  // times ten as shift and add
  assign hum_x10 = {1'b0, hum_q10, 3'b000} + {3'b000, hum_q10, 1'b0};
  assign mag_x10 = {2'b00, mag_q10, 3'b000} + {4'b0000, mag_q10, 1'b0};
  assign hum_rem = {1'b0, hum} - hum_x10;
  assign mag_rem = {2'b00, mag} - mag_x10;

  always_comb begin
    res_d = '0;
    if (ok) begin
      res_d.checksum_ok          = 1'b1;
      res_d.humidity_whole       = hum_q10;
      res_d.humidity_tenths      = hum_rem[htpfd_pkg::TENTHS_W-1:0];
      res_d.temperature_negative = b2[7];
      res_d.temperature_whole    = mag_q10;
      res_d.temperature_tenths   = mag_rem[htpfd_pkg::TENTHS_W-1:0];
    end
  end

  assign frame_ready_o = !out_vld_q || result_o.ready;
  assign load          = frame_i.valid && frame_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (frame_ready_o) begin
      out_vld_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign result_o.valid                = out_vld_q;
  assign result_o.checksum_ok          = res_q.checksum_ok;
  assign result_o.humidity_whole       = res_q.humidity_whole;
  assign result_o.humidity_tenths      = res_q.humidity_tenths;
  assign result_o.temperature_negative = res_q.temperature_negative;
  assign result_o.temperature_whole    = res_q.temperature_whole;
  assign result_o.temperature_tenths   = res_q.temperature_tenths;

endmodule

### rtl/core/humidity_temp_pulse_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// humidity_temp_pulse_frame_decoder_unit
// decodes 40 pulse widths into checksum status, humidity and temperature
// ----------------------------------------------------------------------------
// path: once its 40th pulse item is accepted, a frame passes through the frame
//   register, then the result register, before its result is valid
// throughput: one pulse item per cycle, set by the shift and count, unless a held frame waits on a stalled result
// reset: frame bits, bit count and both valids clear; window registers return
//   to 20 and 30
module humidity_temp_pulse_frame_decoder_unit #(
  parameter int unsigned WIDTH_BITS = htpfd_pkg::WIDTH_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [htpfd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WIDTH_BITS-1:0]           cfg_wdata_i,
  htpfd_pulse_if.sink                     pulse_i,
  htpfd_result_if.source                  result_o
);

  logic [WIDTH_BITS-1:0] zero_min_q, zero_max_q;
  htpfd_pkg::frame_t     frame;
  logic                  frame_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_min_q <= WIDTH_BITS'(htpfd_pkg::ZERO_MIN_RST);
      zero_max_q <= WIDTH_BITS'(htpfd_pkg::ZERO_MAX_RST);
    end else if (cfg_we_i) begin
      unique case (htpfd_pkg::cfg_idx_e'(cfg_idx_i))
        htpfd_pkg::CFG_ZERO_WIDTH_MIN: zero_min_q <= cfg_wdata_i;
        htpfd_pkg::CFG_ZERO_WIDTH_MAX: zero_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  htpfd_accum #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .zero_min_i    (zero_min_q),
    .zero_max_i    (zero_max_q),
    .pulse_i       (pulse_i),
    .frame_o       (frame),
    .frame_ready_i (frame_ready)
  );

  htpfd_decode u_decode (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_i       (frame),
    .frame_ready_o (frame_ready),
    .result_o      (result_o)
  );

endmodule

### rtl/core/htpfd_checker.sv
// ----------------------------------------------------------------------------
// htpfd_checker
// port-level checks on the result channel of the frame decoder
// ----------------------------------------------------------------------------
module htpfd_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic                              checksum_ok_i,
  input logic [htpfd_pkg::HUM_WHOLE_W-1:0] humidity_whole_i,
  input logic [htpfd_pkg::TENTHS_W-1:0]    humidity_tenths_i,
  input logic                              temperature_negative_i,
  input logic [htpfd_pkg::TMP_WHOLE_W-1:0] temperature_whole_i,
  input logic [htpfd_pkg::TENTHS_W-1:0]    temperature_tenths_i
);

  // stalled item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  // failed checksum zeroes every field
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !checksum_ok_i |->
      humidity_whole_i == '0 && humidity_tenths_i == '0 &&
      !temperature_negative_i && temperature_whole_i == '0 &&
      temperature_tenths_i == '0)
    else $error("fields not zero on checksum failure");

  // tenths are single decimal digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> humidity_tenths_i <= htpfd_pkg::TENTHS_W'(9) &&
                    temperature_tenths_i <= htpfd_pkg::TENTHS_W'(9))
    else $error("tenths digit out of range");

endmodule

bind humidity_temp_pulse_frame_decoder_unit htpfd_checker u_htpfd_checker (
  .clk_i                  (clk_i),
  .rst_ni                 (rst_ni),
  .out_valid_i            (result_o.valid),
  .out_ready_i            (result_o.ready),
  .checksum_ok_i          (result_o.checksum_ok),
  .humidity_whole_i       (result_o.humidity_whole),
  .humidity_tenths_i      (result_o.humidity_tenths),
  .temperature_negative_i (result_o.temperature_negative),
  .temperature_whole_i    (result_o.temperature_whole),
  .temperature_tenths_i   (result_o.temperature_tenths)
);

### sim/humidity_temp_pulse_frame_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// humidity_temp_pulse_frame_decoder_unit_test
// Feeds pulse-width items through the decoder under random handshake gaps and
// stalls, over several zero-width windows written between phases. Directed
// frames cover the extreme readings, a bad checksum, a negative temperature,
// a restart in the middle of a frame and a frame with no start marker. Random
// frames follow. Every decoded reading is checked field by field against a
// prediction built from the accepted pulses.
// ----------------------------------------------------------------------------
import htpfd_pkg::*;

class reading_scoreboard;
  logic [WIDTH_BITS-1:0] zero_min;
  logic [WIDTH_BITS-1:0] zero_max;
  logic [FRAME_BITS-1:0] frame_bits;
  int unsigned           bit_count;
  result_t               readings_due[$];
  int unsigned           readings_predicted;
  int unsigned           failures;

  function new();
    zero_min           = WIDTH_BITS'(ZERO_MIN_RST);
    zero_max           = WIDTH_BITS'(ZERO_MAX_RST);
    frame_bits         = '0;
    bit_count          = 0;
    readings_predicted = 0;
    failures           = 0;
  endfunction

  function void set_window(cfg_idx_e idx, logic [WIDTH_BITS-1:0] value);
    case (idx)
      CFG_ZERO_WIDTH_MIN: zero_min = value;
      CFG_ZERO_WIDTH_MAX: zero_max = value;
      default: ;
    endcase
  endfunction

  function void take_pulse(logic [WIDTH_BITS-1:0] width, logic frame_start);
    logic        one_bit;
    logic [15:0] hum;
    logic [15:0] tmp;
    logic [7:0]  chk;
    logic [7:0]  sum;
    result_t     want;
    if (frame_start) begin
      frame_bits = '0;
      bit_count  = 0;
    end
    one_bit    = !(width >= zero_min && width <= zero_max);
    frame_bits = {frame_bits[FRAME_BITS-2:0], one_bit};
    bit_count++;
    if (bit_count == FRAME_BITS) begin
      hum  = frame_bits[39:24];
      tmp  = frame_bits[23:8];
      chk  = frame_bits[7:0];
      sum  = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];
      want = '0;
      if (sum == chk) begin
        want.checksum_ok          = 1'b1;
        want.humidity_whole       = HUM_WHOLE_W'(hum / 16'd10);
        want.humidity_tenths      = TENTHS_W'(hum % 16'd10);
        want.temperature_negative = tmp[15];
        want.temperature_whole    = TMP_WHOLE_W'(tmp[14:0] / 15'd10);
        want.temperature_tenths   = TENTHS_W'(tmp[14:0] % 15'd10);
      end
      readings_due.push_back(want);
      readings_predicted++;
      frame_bits = '0;
      bit_count  = 0;
    end
  endfunction

  function void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endfunction

  function void match_reading(result_t got);
    result_t want;
    if (readings_due.size() == 0) begin
      $error("reading item with none outstanding");
      failures++;
      return;
    end
    want = readings_due.pop_front();
    compare_field("checksum_ok", 16'(want.checksum_ok), 16'(got.checksum_ok));
    compare_field("humidity_whole", 16'(want.humidity_whole), 16'(got.humidity_whole));
    compare_field("humidity_tenths", 16'(want.humidity_tenths), 16'(got.humidity_tenths));
    compare_field("temperature_negative", 16'(want.temperature_negative),
                  16'(got.temperature_negative));
    compare_field("temperature_whole", 16'(want.temperature_whole),
                  16'(got.temperature_whole));
    compare_field("temperature_tenths", 16'(want.temperature_tenths),
                  16'(got.temperature_tenths));
  endfunction

  function int unsigned pending();
    return readings_due.size();
  endfunction
endclass

module humidity_temp_pulse_frame_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIDTH_MAX   = (1 << WIDTH_BITS) - 1;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 7;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [WIDTH_BITS-1:0] cfg_wdata_i;

  htpfd_pulse_if  pulse_ch ();
  htpfd_result_if result_ch ();

  humidity_temp_pulse_frame_decoder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pulse_i     (pulse_ch),
    .result_o    (result_ch)
  );

  reading_scoreboard sb = new();
  int unsigned pulses_sent  = 0;
  int unsigned send_quiet   = 0;
  int unsigned recv_quiet   = 0;
  int unsigned cycle_count  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // random gap per item, with occasional runs of back-to-back items
  function automatic int unsigned draw_wait(ref int unsigned quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // width that decodes to the wanted bit under the current window, where one exists
  function automatic logic [WIDTH_BITS-1:0] width_for(logic one_bit);
    int unsigned lo;
    int unsigned hi;
    int unsigned pick;
    int unsigned w;
    lo   = sb.zero_min;
    hi   = sb.zero_max;
    pick = $urandom_range(0, 5);
    w    = $urandom_range(0, WIDTH_MAX);
    if (lo <= hi) begin
      if (!one_bit) begin
        case (pick)
          0: w = lo;
          1: w = hi;
          default: w = $urandom_range(hi, lo);
        endcase
      end else if (lo > 0 && (hi == WIDTH_MAX || $urandom_range(0, 1) == 0)) begin
        case (pick)
          0: w = 0;
          1: w = lo - 1;
          default: w = $urandom_range(lo - 1, 0);
        endcase
      end else if (hi < WIDTH_MAX) begin
        case (pick)
          0: w = WIDTH_MAX;
          1: w = hi + 1;
          default: w = $urandom_range(WIDTH_MAX, hi + 1);
        endcase
      end
    end
    return WIDTH_BITS'(w);
  endfunction

  function automatic logic [FRAME_BITS-1:0] make_frame(logic [15:0] hum, logic [15:0] tmp,
                                                       logic good);
    logic [7:0] chk;
    chk = hum[15:8] + hum[7:0] + tmp[15:8] + tmp[7:0];
    if (!good) chk = chk ^ 8'($urandom_range(1, 255));
    return {hum, tmp, chk};
  endfunction

  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 7))
      0: return 16'hffff;
      1: return 16'h0000;
      2: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pulse(logic [WIDTH_BITS-1:0] width, logic start);
    int unsigned gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      pulse_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pulse_ch.valid       <= 1'b1;
    pulse_ch.pulse_width <= width;
    pulse_ch.frame_start <= start;
    do @(posedge clk_i); while (!pulse_ch.ready);
    sb.take_pulse(width, start);
    pulses_sent++;
  endtask

  task automatic send_bits(logic [FRAME_BITS-1:0] frame, int unsigned count, logic start);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      send_pulse(width_for(frame[FRAME_BITS-1-i]), (i == 0) ? start : 1'b0);
    end
  endtask

  task automatic drain();
    pulse_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(logic [WIDTH_BITS-1:0] lo, logic [WIDTH_BITS-1:0] hi);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ZERO_WIDTH_MIN;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_ZERO_WIDTH_MAX;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_window(CFG_ZERO_WIDTH_MIN, lo);
    sb.set_window(CFG_ZERO_WIDTH_MAX, hi);
  endtask

  task automatic run_random(int unsigned item_goal);
    int unsigned items_at;
    int unsigned readings_at;
    items_at    = pulses_sent;
    readings_at = sb.readings_predicted;
    while (pulses_sent - items_at < item_goal || sb.readings_predicted - readings_at < 2) begin
      case ($urandom_range(0, 9))
        8: send_bits(make_frame(random_word(), random_word(), 1'b1), $urandom_range(1, 39),
                     1'b1);
        9: repeat ($urandom_range(1, 20)) begin
          send_pulse(WIDTH_BITS'($urandom_range(0, WIDTH_MAX)), $urandom_range(0, 7) == 0);
        end
        default: send_bits(make_frame(random_word(), random_word(), $urandom_range(0, 6) != 0),
                           FRAME_BITS, $urandom_range(0, 4) != 0);
      endcase
    end
  endtask

  // window bounds and item goals per phase; both bounds of phase 5, counting from 0, are redrawn
  int unsigned win_lo[PHASES]  = '{0, 1023, 0, 1023, 300, 0, 20};
  int unsigned win_hi[PHASES]  = '{1023, 0, 0, 1023, 700, 0, 30};
  int unsigned goal[PHASES]    = '{100, 100, 140, 140, 160, 160, 170};

  initial begin
    int unsigned p;
    int unsigned lo;
    int unsigned hi;
    rst_ni               <= 1'b0;
    cfg_we_i             <= 1'b0;
    cfg_idx_i            <= CFG_ZERO_WIDTH_MIN;
    cfg_wdata_i          <= '0;
    pulse_ch.valid       <= 1'b0;
    pulse_ch.pulse_width <= '0;
    pulse_ch.frame_start <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames under the reset window
    send_bits(make_frame(16'hffff, 16'hffff, 1'b1), FRAME_BITS, 1'b1);
    send_bits(make_frame(16'h0000, 16'h0000, 1'b1), FRAME_BITS, 1'b1);
    send_bits(make_frame(16'h1234, 16'h8123, 1'b0), FRAME_BITS, 1'b1);
    send_bits(make_frame(16'd652, 16'h8065, 1'b1), FRAME_BITS, 1'b1);
    send_bits(make_frame(16'hbeef, 16'h0123, 1'b1), 17, 1'b1);
    send_bits(make_frame(16'h0001, 16'h7fff, 1'b1), FRAME_BITS, 1'b1);
    send_bits(make_frame(16'd999, 16'h8000, 1'b1), FRAME_BITS, 1'b0);

    for (p = 0; p < PHASES; p++) begin
      drain();
      lo = win_lo[p];
      hi = win_hi[p];
      if (p == 5) begin
        lo = $urandom_range(0, 700);
        hi = lo + $urandom_range(0, 300);
      end
      write_window(WIDTH_BITS'(lo), WIDTH_BITS'(hi));
      run_random(goal[p]);
    end

    drain();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    int unsigned stall;
    result_t     got;
    result_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
      got.checksum_ok          = result_ch.checksum_ok;
      got.humidity_whole       = result_ch.humidity_whole;
      got.humidity_tenths      = result_ch.humidity_tenths;
      got.temperature_negative = result_ch.temperature_negative;
      got.temperature_whole    = result_ch.temperature_whole;
      got.temperature_tenths   = result_ch.temperature_tenths;
      sb.match_reading(got);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

endmodule
